// ----- sv/incremental_pid_error_window_core_defines.svh -----
// ---------------------------------------------------------------------------
// incremental pid error window core - assertion macros
// shared property shells for the checks at the end of the core rtl module
// ---------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_ERROR_WINDOW_CORE_DEFINES_SVH
`define INCREMENTAL_PID_ERROR_WINDOW_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define IPID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define IPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ipid_pkg.sv -----
// ---------------------------------------------------------------------------
// ipid_pkg - shared types and constants
// number formats, widths of the digit-serial datapath and status codes
// ---------------------------------------------------------------------------
package ipid_pkg;

    // number formats
    localparam int DATA_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 4;

    // error and difference widths (signed)
    localparam int ERR_BITS   = DATA_BITS + 1;
    localparam int DIFF1_BITS = DATA_BITS + 2;
    localparam int DIFF2_BITS = DATA_BITS + 3;

    // digit-serial multiplier geometry
    localparam int DIGIT_BITS  = 4;
    localparam int MULT_DIGITS = (DIFF2_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int MULT_BITS   = MULT_DIGITS * DIGIT_BITS;
    localparam int MACC_BITS   = GAIN_BITS + DIGIT_BITS + 4;
    localparam int SUM_BITS    = GAIN_BITS + DIFF2_BITS + 1;

    localparam int SCALE_DIGITS = (GAIN_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int SCALE_SR_BITS = SCALE_DIGITS * DIGIT_BITS;
    localparam int MAG_BITS     = SUM_BITS - GAIN_FRAC_BITS;
    localparam int SACC_BITS    = MAG_BITS + DIGIT_BITS + 1;
    localparam int PROD_BITS    = MAG_BITS + GAIN_BITS;

    // scaled increment
    localparam int M_BITS      = DATA_BITS + 2;
    localparam int SCALED_BITS = DATA_BITS + 3;

    // stream payload
    localparam int IN_TDATA_BITS  = ((2 * DATA_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = DATA_BITS + 3;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = (GAIN_BITS > DATA_BITS) ? GAIN_BITS : DATA_BITS;

    typedef logic signed [GAIN_BITS-1:0] t_gain;
    typedef logic        [DATA_BITS-1:0] t_data;

    // rounding constants
    localparam logic [GAIN_FRAC_BITS:0] ROUND_HALF = (GAIN_FRAC_BITS+1)'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [PROD_BITS-1:0]    PROD_LIM   =
        PROD_BITS'(1) << (DATA_BITS + GAIN_FRAC_BITS + 1);
    localparam logic [M_BITS-1:0]       M_SAT      = M_BITS'(1) << (DATA_BITS + 1);
    localparam t_gain                   SCALE_ONE  = GAIN_BITS'(1) << GAIN_FRAC_BITS;

    // saturation code of a result
    typedef enum logic [1:0] {
        SAT_NONE  = 2'd0,
        SAT_UPPER = 2'd1,
        SAT_LOWER = 2'd2
    } t_sat;

    // configuration register index
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_I       = 3'd1,
        CFG_GAIN_D       = 3'd2,
        CFG_OUT_UPPER    = 3'd3,
        CFG_OUT_LOWER    = 3'd4,
        CFG_WINDOW_LOW   = 3'd5,
        CFG_WINDOW_HIGH  = 3'd6,
        CFG_WINDOW_SCALE = 3'd7
    } t_cfg_idx;

endpackage

// ----- sv/ipid_gain_mac.sv -----
// ---------------------------------------------------------------------------
// ipid_gain_mac - digit-serial gain sum
// forms kp*d1 + ki*e + kd*d2 one radix-16 digit of the multipliers per cycle
// ---------------------------------------------------------------------------
module ipid_gain_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  ipid_pkg::t_gain                       i_gain_p,
    input  ipid_pkg::t_gain                       i_gain_i,
    input  ipid_pkg::t_gain                       i_gain_d,
    input  logic signed [ipid_pkg::DIFF1_BITS-1:0] i_diff1,
    input  logic signed [ipid_pkg::ERR_BITS-1:0]   i_err,
    input  logic signed [ipid_pkg::DIFF2_BITS-1:0] i_diff2,
    output logic                                  o_done,
    output logic signed [ipid_pkg::SUM_BITS-1:0]   o_sum
);
    import ipid_pkg::*;

    localparam int CNT_BITS = (MULT_DIGITS > 1) ? $clog2(MULT_DIGITS) : 1;
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(MULT_DIGITS - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_BITS-1:0]           r_cnt;
    logic [MULT_BITS-1:0]          r_m1;
    logic [MULT_BITS-1:0]          r_m0;
    logic [MULT_BITS-1:0]          r_m2;
    logic signed [MACC_BITS-1:0]   r_hi;
    logic [MULT_BITS-1:0]          r_lo;

    logic                          w_top;
    logic signed [DIGIT_BITS:0]    w_dg1;
    logic signed [DIGIT_BITS:0]    w_dg0;
    logic signed [DIGIT_BITS:0]    w_dg2;
    logic signed [GAIN_BITS+DIGIT_BITS:0] w_p1;
    logic signed [GAIN_BITS+DIGIT_BITS:0] w_p0;
    logic signed [GAIN_BITS+DIGIT_BITS:0] w_p2;
    logic signed [MACC_BITS-1:0]   w_t;

    // current digits, the most significant one carries the sign
    assign w_top = (r_cnt == LAST);
    assign w_dg1 = $signed({w_top & r_m1[DIGIT_BITS-1], r_m1[DIGIT_BITS-1:0]});
    assign w_dg0 = $signed({w_top & r_m0[DIGIT_BITS-1], r_m0[DIGIT_BITS-1:0]});
    assign w_dg2 = $signed({w_top & r_m2[DIGIT_BITS-1], r_m2[DIGIT_BITS-1:0]});

    // three narrow gain-by-digit products and their sum with the running high part
    assign w_p1 = i_gain_p * w_dg1;
    assign w_p0 = i_gain_i * w_dg0;
    assign w_p2 = i_gain_d * w_dg2;
    assign w_t  = r_hi + MACC_BITS'(w_p1) + MACC_BITS'(w_p0) + MACC_BITS'(w_p2);

    // digit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (w_top) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // multiplier shift registers and product halves
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m1 <= MULT_BITS'(i_diff1);
            r_m0 <= MULT_BITS'(i_err);
            r_m2 <= MULT_BITS'(i_diff2);
            r_hi <= '0;
        end else if (r_busy) begin
            r_m1 <= r_m1 >> DIGIT_BITS;
            r_m0 <= r_m0 >> DIGIT_BITS;
            r_m2 <= r_m2 >> DIGIT_BITS;
            r_hi <= w_t >>> DIGIT_BITS;
            r_lo <= {w_t[DIGIT_BITS-1:0], r_lo[MULT_BITS-1:DIGIT_BITS]};
        end
    end

    assign o_done = r_done;
    assign o_sum  = $signed({r_hi[SUM_BITS-MULT_BITS-1:0], r_lo});

endmodule

// ----- sv/ipid_scale_mul.sv -----
// ---------------------------------------------------------------------------
// ipid_scale_mul - digit-serial magnitude multiplier
// multiplies the rounded increment magnitude by the window scale magnitude
// ---------------------------------------------------------------------------
module ipid_scale_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ipid_pkg::MAG_BITS-1:0]     i_mag,
    input  logic [ipid_pkg::GAIN_BITS-1:0]    i_scale_mag,
    output logic                              o_done,
    output logic [ipid_pkg::PROD_BITS-1:0]    o_prod
);
    import ipid_pkg::*;

    localparam int CNT_BITS = (SCALE_DIGITS > 1) ? $clog2(SCALE_DIGITS) : 1;
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(SCALE_DIGITS - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_BITS-1:0]        r_cnt;
    logic [MAG_BITS-1:0]        r_mag;
    logic [SCALE_SR_BITS-1:0]   r_sc;
    logic [SACC_BITS-1:0]       r_hi;
    logic [SCALE_SR_BITS-1:0]   r_lo;
    logic [SACC_BITS-1:0]       w_t;

    // running high part plus magnitude times the current scale digit
    assign w_t = r_hi + SACC_BITS'(r_mag) * SACC_BITS'(r_sc[DIGIT_BITS-1:0]);

    // digit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // scale shift register and product halves
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_sc  <= SCALE_SR_BITS'(i_scale_mag);
            r_hi  <= '0;
        end else if (r_busy) begin
            r_sc <= r_sc >> DIGIT_BITS;
            r_hi <= w_t >> DIGIT_BITS;
            r_lo <= {w_t[DIGIT_BITS-1:0], r_lo[SCALE_SR_BITS-1:DIGIT_BITS]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[PROD_BITS-SCALE_SR_BITS-1:0], r_lo};

endmodule

// ----- sv/incremental_pid_error_window_core.sv -----
// ---------------------------------------------------------------------------
// incremental_pid_error_window_core - velocity-form pid with error window
// error, digit-serial gain sum, rounding, windowed scaling, clamped accumulator
// ---------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s         in         i_s_tvalid/o_s_tready  setpoint, measurement
//  m         out        o_m_tvalid/i_m_tready  drive, saturation, in_window
//  cfg       in         i_cfg_we               i_cfg_idx, i_cfg_data
//
//  one request runs through the digit-serial gain sum, the digit-serial scale
//  multiply and the load, rounding and clamping steps
//  a new request is taken once the previous result sits in the output register
//  the output register holds a result while i_m_tready is low; the last stage
//  waits there only if a second result is ready before the first was taken
//  synchronous active-low reset clears state, presets gains, bounds and scale
// ---------------------------------------------------------------------------
`include "incremental_pid_error_window_core_defines.svh"

module incremental_pid_error_window_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // setpoint [15:0], measurement [31:16]
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [ipid_pkg::IN_TDATA_BITS-1:0]    i_s_tdata,
    // drive [15:0], saturation [17:16], in_window [18], zero fill above
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [ipid_pkg::OUT_TDATA_BITS-1:0]   o_m_tdata,
    // register write port
    input  logic                                  i_cfg_we,
    input  logic [ipid_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [ipid_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import ipid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_ROUND,
        S_SCALE,
        S_CLAMP
    } t_state;

    // configuration registers
    t_gain  r_gain_p;
    t_gain  r_gain_i;
    t_gain  r_gain_d;
    t_data  r_out_upper;
    t_data  r_out_lower;
    t_data  r_window_low;
    t_data  r_window_high;
    t_gain  r_window_scale;

    // control and state
    t_state                        r_state;
    logic signed [ERR_BITS-1:0]    r_e1;
    logic signed [ERR_BITS-1:0]    r_e2;
    t_data                         r_acc;
    logic                          r_inwin;
    logic [MAG_BITS-1:0]           r_md;
    logic                          r_dneg;
    logic signed [SCALED_BITS-1:0] r_scaled;
    logic                          r_out_valid;
    t_data                         r_out_drive;
    t_sat                          r_out_sat;
    logic                          r_out_inwin;

    logic                          w_in_acc;
    logic                          w_m_acc;
    t_data                         w_sp;
    t_data                         w_ms;
    logic signed [ERR_BITS-1:0]    w_e;
    logic [ERR_BITS-1:0]           w_e_mag;
    t_data                         w_abs_e;
    logic                          w_inwin;
    logic signed [DIFF1_BITS-1:0]  w_d1;
    logic signed [DIFF2_BITS-1:0]  w_d2;
    logic                          w_gain_done;
    logic signed [SUM_BITS-1:0]    w_sum;
    logic [SUM_BITS-1:0]           w_sum_mag;
    logic [SUM_BITS-1:0]           w_sum_rnd;
    logic                          w_scale_start;
    logic [GAIN_BITS-1:0]          w_scale_mag;
    logic                          w_scale_done;
    logic [PROD_BITS-1:0]          w_prod;
    logic [PROD_BITS-1:0]          w_prod_rnd;
    logic [M_BITS-1:0]             w_m;
    logic signed [SCALED_BITS-1:0] w_m_s;
    logic                          w_neg;
    logic signed [SCALED_BITS-1:0] w_f;
    logic signed [SCALED_BITS-1:0] w_upper_s;
    logic signed [SCALED_BITS-1:0] w_lower_s;
    t_data                         w_drive;
    t_sat                          w_sat;
    logic                          w_out_load;

    // handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_m_acc    = r_out_valid && i_m_tready;
    assign w_out_load = (r_state == S_CLAMP) && (!r_out_valid || i_m_tready);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= '0;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_out_upper    <= '1;
            r_out_lower    <= '0;
            r_window_low   <= '0;
            r_window_high  <= '1;
            r_window_scale <= SCALE_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:       r_gain_p       <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_I:       r_gain_i       <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_D:       r_gain_d       <= i_cfg_data[GAIN_BITS-1:0];
                CFG_OUT_UPPER:    r_out_upper    <= i_cfg_data[DATA_BITS-1:0];
                CFG_OUT_LOWER:    r_out_lower    <= i_cfg_data[DATA_BITS-1:0];
                CFG_WINDOW_LOW:   r_window_low   <= i_cfg_data[DATA_BITS-1:0];
                CFG_WINDOW_HIGH:  r_window_high  <= i_cfg_data[DATA_BITS-1:0];
                CFG_WINDOW_SCALE: r_window_scale <= i_cfg_data[GAIN_BITS-1:0];
                default:          r_gain_p       <= r_gain_p;
            endcase
        end
    end

    // error, window test and the two differences
    assign w_sp    = i_s_tdata[DATA_BITS-1:0];
    assign w_ms    = i_s_tdata[2*DATA_BITS-1:DATA_BITS];
    assign w_e     = $signed({1'b0, w_sp}) - $signed({1'b0, w_ms});
    assign w_e_mag = w_e[ERR_BITS-1] ? ERR_BITS'(-w_e) : ERR_BITS'(w_e);
    assign w_abs_e = w_e_mag[DATA_BITS-1:0];
    assign w_inwin = (w_abs_e >= r_window_low) && (w_abs_e <= r_window_high);
    assign w_d1    = DIFF1_BITS'(w_e) - DIFF1_BITS'(r_e1);
    assign w_d2    = DIFF2_BITS'(w_e) - (DIFF2_BITS'(r_e1) <<< 1) + DIFF2_BITS'(r_e2);

    ipid_gain_mac u_gain_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in_acc),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .i_diff1  (w_d1),
        .i_err    (w_e),
        .i_diff2  (w_d2),
        .o_done   (w_gain_done),
        .o_sum    (w_sum)
    );

    // round the gain sum to nearest, ties away from zero
    assign w_sum_mag = w_sum[SUM_BITS-1] ? SUM_BITS'(-w_sum) : SUM_BITS'(w_sum);
    assign w_sum_rnd = w_sum_mag + SUM_BITS'(ROUND_HALF);

    // scale magnitude and multiplier
    assign w_scale_start = (r_state == S_ROUND);
    assign w_scale_mag   = r_window_scale[GAIN_BITS-1] ? GAIN_BITS'(-r_window_scale)
                                                       : GAIN_BITS'(r_window_scale);

    ipid_scale_mul u_scale_mul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_scale_start),
        .i_mag       (r_md),
        .i_scale_mag (w_scale_mag),
        .o_done      (w_scale_done),
        .o_prod      (w_prod)
    );

    // rounded scaled magnitude, saturated when the product runs past the limit
    assign w_prod_rnd = w_prod + PROD_BITS'(ROUND_HALF);
    assign w_m        = (w_prod > PROD_LIM) ? M_SAT : w_prod_rnd[GAIN_FRAC_BITS +: M_BITS];
    assign w_m_s      = $signed({1'b0, w_m});
    assign w_neg      = r_dneg ^ r_window_scale[GAIN_BITS-1];

    // accumulate and clamp, upper bound tested first
    assign w_f       = $signed({{(SCALED_BITS-DATA_BITS){1'b0}}, r_acc}) + r_scaled;
    assign w_upper_s = $signed({{(SCALED_BITS-DATA_BITS){1'b0}}, r_out_upper});
    assign w_lower_s = $signed({{(SCALED_BITS-DATA_BITS){1'b0}}, r_out_lower});

    always_comb begin
        priority if (w_f >= w_upper_s) begin
            w_drive = r_out_upper;
            w_sat   = SAT_UPPER;
        end else if (w_f <= w_lower_s) begin
            w_drive = r_out_lower;
            w_sat   = SAT_LOWER;
        end else begin
            w_drive = w_f[DATA_BITS-1:0];
            w_sat   = SAT_NONE;
        end
    end

    // sequencer, error history, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_e1        <= '0;
            r_e2        <= '0;
        end else begin
            if (w_m_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_inwin <= w_inwin;
                        r_e2    <= r_e1;
                        r_e1    <= w_inwin ? w_e : '0;
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (w_gain_done) begin
                        r_md    <= w_sum_rnd[SUM_BITS-1:GAIN_FRAC_BITS];
                        r_dneg  <= w_sum[SUM_BITS-1];
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (w_scale_done) begin
                        r_scaled <= !r_inwin ? '0 : (w_neg ? -w_m_s : w_m_s);
                        r_state  <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (w_out_load) begin
                        r_acc       <= w_drive;
                        r_out_drive <= w_drive;
                        r_out_sat   <= w_sat;
                        r_out_inwin <= r_inwin;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_BITS'({r_out_inwin, r_out_sat, r_out_drive});

    // checks
    `IPID_ASSERT_NOW(a_gain_done_in_gain, w_gain_done, r_state == S_GAIN, "gain sum finished outside the gain phase")
    `IPID_ASSERT_NOW(a_scale_done_in_scale, w_scale_done, r_state == S_SCALE, "scale product finished outside the scale phase")
    `IPID_ASSERT_NOW(a_round_after_gain, r_state == S_ROUND, $past(w_gain_done), "scale started without a fresh gain sum")
    `IPID_ASSERT_NEXT(a_out_window_clears_err, w_in_acc && !w_inwin, r_e1 == '0, "error kept although outside the window")
    `IPID_ASSERT_NEXT(a_err_history_shift, w_in_acc, r_e2 == $past(r_e1), "error history did not shift on a request")

endmodule
